// File: rtl/cda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cda_pkg: shared types and tables for the calendar date arithmetic block
// Opcodes, order codes, Gregorian month tables and range limits.
// ----------------------------------------------------------------------------
package cda_pkg;

  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_SUB     = 2'd1,
    OP_BETWEEN = 2'd2,
    OP_COMPARE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ORD_EQUAL = 2'd0,
    ORD_BEFORE = 2'd1,
    ORD_AFTER = 2'd2
  } ord_t;

  localparam logic [13:0] YEAR_MAX  = 14'd9999;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  // Reciprocal of 100 scaled by 2^19, exact for every 14-bit year.
  localparam logic [26:0] RECIP_100 = 27'd5243;
  localparam int          RECIP_SH  = 19;

  // Length of a month; zero for codes that are not a month.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && (m > 4'd2)) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// File: rtl/calendar_date_arithmetic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_arithmetic: Gregorian date add, subtract, distance, compare
// A small sequencer drives one shared year unit and a month stepper.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | opcode, date A, date B, delta_days
//  out_    | output    | out_valid/out_stall | result date, count, order, flags
//
// One word is worked on at a time; in_stall stays high until its result is taken.
// Between and compare pass through S_A1, S_A2, S_B1, S_B2, S_NUM and S_DIFF
// to S_OUT. Add and subtract step one month per cycle, plus a pass through
// the shared year unit (S_L1, S_L2) at each year wrap.
// Synchronous active-low reset returns the sequencer to idle, no result pending.
// A stalled result holds its value until out_stall drops.
module calendar_date_arithmetic
  import cda_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [13:0] in_a_year,
  input  wire logic [3:0]  in_a_month,
  input  wire logic [4:0]  in_a_day,
  input  wire logic [13:0] in_b_year,
  input  wire logic [3:0]  in_b_month,
  input  wire logic [4:0]  in_b_date_day,
  input  wire logic [15:0] in_delta_days,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [13:0]      out_res_year,
  output logic [3:0]       out_res_month,
  output logic [4:0]       out_res_day,
  output logic [15:0]      out_days_count,
  output logic [1:0]       out_order,
  output logic             out_input_valid,
  output logic             out_saturated
);

  typedef enum logic [3:0] {
    S_IDLE, S_A1, S_A2, S_B1, S_B2, S_NUM, S_DIFF, S_STEP, S_L1, S_L2, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  op_t         op_r, op_nxt;
  logic [13:0] y_r, y_nxt;
  logic [3:0]  m_r, m_nxt;
  logic [4:0]  d_r, d_nxt;
  logic [13:0] by_r, by_nxt;
  logic [3:0]  bm_r, bm_nxt;
  logic [4:0]  bd_r, bd_nxt;
  logic [15:0] r_r, r_nxt;
  logic        leap_r, leap_nxt;
  logic [21:0] dby_a_r, dby_a_nxt;
  logic [21:0] na_r, na_nxt;
  logic [21:0] nb_r, nb_nxt;
  logic [13:0] uy_r, uy_nxt;
  logic [6:0]  q100_r, q100_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  ord_t        ord_r, ord_nxt;
  logic        valid_r, valid_nxt;
  logic        sat_r, sat_nxt;

  // Shared year unit: quotient by 100 through the reciprocal, registered in q100_r.
  logic [13:0] unit_y;
  logic [26:0] unit_prod;
  // From the registered year and quotient: remainder, leap flag and days before the year.
  logic [13:0] unit_rem;
  logic        rem_nz;
  logic        unit_leap;
  logic [21:0] unit_dby;

  // Clamped date B.
  logic [13:0] by_c;
  logic [3:0]  bm_c;
  logic [4:0]  blen;
  logic [4:0]  bd_c;

  logic [4:0]  cur_len;
  logic [4:0]  left_days;
  logic [4:0]  prev_len;
  logic [21:0] diff;

  always_comb begin
    by_c = (by_r > YEAR_MAX) ? YEAR_MAX : by_r;
    if (bm_r < 4'd1) begin
      bm_c = 4'd1;
    end else if (bm_r > 4'd12) begin
      bm_c = 4'd12;
    end else begin
      bm_c = bm_r;
    end
    unit_y    = (state_r == S_B1) ? by_c : y_r;
    unit_prod = {13'd0, unit_y} * RECIP_100;

    unit_rem  = uy_r - ({7'd0, q100_r} * 14'd100);
    rem_nz    = (unit_rem != 14'd0);
    unit_leap = ((uy_r[1:0] == 2'd0) && rem_nz) || (!rem_nz && (q100_r[1:0] == 2'd0));
    // 365*y + ceil(y/4) - ceil(y/100) + ceil(y/400), which is zero for year 0.
    unit_dby  = ({8'd0, uy_r} * 22'd365)
              + {10'd0, uy_r[13:2]} + {21'd0, (uy_r[1:0] != 2'd0)}
              - {15'd0, q100_r} - {21'd0, rem_nz}
              + {17'd0, q100_r[6:2]} + {21'd0, (rem_nz || (q100_r[1:0] != 2'd0))};

    blen = month_len(bm_c, unit_leap);
    if (bd_r < 5'd1) begin
      bd_c = 5'd1;
    end else if (bd_r > blen) begin
      bd_c = blen;
    end else begin
      bd_c = bd_r;
    end

    cur_len   = month_len(m_r, leap_r);
    left_days = cur_len - d_r;
    prev_len  = month_len(m_r - 4'd1, leap_r);
    diff      = (na_r > nb_r) ? (na_r - nb_r) : (nb_r - na_r);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    y_nxt         = y_r;
    m_nxt         = m_r;
    d_nxt         = d_r;
    by_nxt        = by_r;
    bm_nxt        = bm_r;
    bd_nxt        = bd_r;
    r_nxt         = r_r;
    leap_nxt      = leap_r;
    dby_a_nxt     = dby_a_r;
    na_nxt        = na_r;
    nb_nxt        = nb_r;
    uy_nxt        = unit_y;
    q100_nxt      = unit_prod[RECIP_SH+6:RECIP_SH];
    cnt_nxt       = cnt_r;
    ord_nxt       = ord_r;
    valid_nxt     = valid_r;
    sat_nxt       = sat_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = op_t'(in_opcode);
          y_nxt     = in_a_year;
          m_nxt     = in_a_month;
          d_nxt     = in_a_day;
          by_nxt    = in_b_year;
          bm_nxt    = in_b_month;
          bd_nxt    = in_b_date_day;
          r_nxt     = in_delta_days;
          cnt_nxt   = 16'd0;
          ord_nxt   = ORD_EQUAL;
          sat_nxt   = 1'b0;
          state_nxt = S_A1;
        end
      end
      S_A1: state_nxt = S_A2;
      S_A2: begin
        leap_nxt  = unit_leap;
        dby_a_nxt = unit_dby;
        valid_nxt = (y_r <= YEAR_MAX) && (d_r >= 5'd1) && (d_r <= month_len(m_r, unit_leap));
        if (!valid_nxt) begin
          y_nxt         = 14'd0;
          m_nxt         = 4'd1;
          d_nxt         = 5'd1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_OUT;
        end else if ((op_r == OP_ADD) || (op_r == OP_SUB)) begin
          state_nxt = S_STEP;
        end else begin
          state_nxt = S_B1;
        end
      end
      S_B1: state_nxt = S_B2;
      S_B2: begin
        nb_nxt    = unit_dby + {13'd0, days_before_month(bm_c, unit_leap)}
                  + {17'd0, bd_c} - 22'd1;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        na_nxt    = dby_a_r + {13'd0, days_before_month(m_r, leap_r)}
                  + {17'd0, d_r} - 22'd1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        if (op_r == OP_BETWEEN) begin
          if (diff > {6'd0, COUNT_MAX}) begin
            cnt_nxt = COUNT_MAX;
            sat_nxt = 1'b1;
          end else begin
            cnt_nxt = diff[15:0];
          end
        end else if (na_r == nb_r) begin
          ord_nxt = ORD_EQUAL;
        end else if (na_r < nb_r) begin
          ord_nxt = ORD_BEFORE;
        end else begin
          ord_nxt = ORD_AFTER;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_OUT;
      end
      S_STEP: begin
        if (op_r == OP_ADD) begin
          if (r_r <= {11'd0, left_days}) begin
            d_nxt         = d_r + r_r[4:0];
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else if ((y_r == YEAR_MAX) && (m_r == 4'd12)) begin
            d_nxt         = 5'd31;
            sat_nxt       = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            r_nxt = r_r - {11'd0, left_days} - 16'd1;
            d_nxt = 5'd1;
            if (m_r == 4'd12) begin
              m_nxt     = 4'd1;
              y_nxt     = y_r + 14'd1;
              state_nxt = S_L1;
            end else begin
              m_nxt = m_r + 4'd1;
            end
          end
        end else begin
          if (r_r < {11'd0, d_r}) begin
            d_nxt         = d_r - r_r[4:0];
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else if ((y_r == 14'd0) && (m_r == 4'd1)) begin
            d_nxt         = 5'd1;
            sat_nxt       = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_OUT;
          end else begin
            // Subtracting the day of month lands on the last day of the month before.
            r_nxt = r_r - {11'd0, d_r};
            if (m_r == 4'd1) begin
              m_nxt     = 4'd12;
              d_nxt     = 5'd31;
              y_nxt     = y_r - 14'd1;
              state_nxt = S_L1;
            end else begin
              m_nxt = m_r - 4'd1;
              d_nxt = prev_len;
            end
          end
        end
      end
      S_L1: state_nxt = S_L2;
      S_L2: begin
        leap_nxt  = unit_leap;
        state_nxt = S_STEP;
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r    <= op_nxt;
    y_r     <= y_nxt;
    m_r     <= m_nxt;
    d_r     <= d_nxt;
    by_r    <= by_nxt;
    bm_r    <= bm_nxt;
    bd_r    <= bd_nxt;
    r_r     <= r_nxt;
    leap_r  <= leap_nxt;
    dby_a_r <= dby_a_nxt;
    na_r    <= na_nxt;
    nb_r    <= nb_nxt;
    uy_r    <= uy_nxt;
    q100_r  <= q100_nxt;
    cnt_r   <= cnt_nxt;
    ord_r   <= ord_nxt;
    valid_r <= valid_nxt;
    sat_r   <= sat_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_res_year    = y_r;
  assign out_res_month   = m_r;
  assign out_res_day     = d_r;
  assign out_days_count  = cnt_r;
  assign out_order       = ord_r;
  assign out_input_valid = valid_r;
  assign out_saturated   = sat_r;

`ifndef SYNTHESIS
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown one cycle after a word was accepted");

  a_invalid_fixed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_input_valid) |-> ((out_res_year == 14'd0) && (out_res_month == 4'd1)
      && (out_res_day == 5'd1) && (out_days_count == 16'd0) && !out_saturated))
    else $error("invalid date A did not give the fixed result");

  a_step_ops_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((op_r == OP_ADD) || (op_r == OP_SUB)))
      |-> ((out_days_count == 16'd0) && (out_order == ORD_EQUAL)))
    else $error("add or subtract produced a count or order");

  a_result_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_res_month >= 4'd1) && (out_res_month <= 4'd12)
      && (out_res_day >= 5'd1) && (out_res_year <= YEAR_MAX)))
    else $error("result date out of range");

  a_stall_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");
`endif

endmodule
`default_nettype wire

// File: tb/sv/calendar_date_arithmetic_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_arithmetic_tb: self-checking bench for the Gregorian date unit
// Sends directed and random words through the valid/stall input channel and
// checks every result word against a day-number predictor of add, subtract,
// days-between and compare, with random idling on both channels.
// ----------------------------------------------------------------------------
module calendar_date_arithmetic_tb;
  import cda_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 4000000;
  localparam int unsigned DAYS_PER_400Y = 146097;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } cal_date_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [15:0] count;
    logic [1:0]  order;
    logic        valid;
    logic        sat;
  } date_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_opcode = '0;
  logic [13:0] in_a_year = '0;
  logic [3:0]  in_a_month = '0;
  logic [4:0]  in_a_day = '0;
  logic [13:0] in_b_year = '0;
  logic [3:0]  in_b_month = '0;
  logic [4:0]  in_b_date_day = '0;
  logic [15:0] in_delta_days = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [13:0] out_res_year;
  logic [3:0]  out_res_month;
  logic [4:0]  out_res_day;
  logic [15:0] out_days_count;
  logic [1:0]  out_order;
  logic        out_input_valid;
  logic        out_saturated;

  date_result_t expected_q[$];
  int          sender_idle_pct = 0;
  int          receiver_idle_pct = 0;
  int          error_count = 0;
  int          words_sent = 0;
  int          results_checked = 0;
  int          sat_words = 0;
  int          invalid_words = 0;
  int unsigned cycle_count = 0;

  calendar_date_arithmetic uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_a_year      (in_a_year),
    .in_a_month     (in_a_month),
    .in_a_day       (in_a_day),
    .in_b_year      (in_b_year),
    .in_b_month     (in_b_month),
    .in_b_date_day  (in_b_date_day),
    .in_delta_days  (in_delta_days),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_res_year   (out_res_year),
    .out_res_month  (out_res_month),
    .out_res_day    (out_res_day),
    .out_days_count (out_days_count),
    .out_order      (out_order),
    .out_input_valid(out_input_valid),
    .out_saturated  (out_saturated)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- calendar
  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // Day number of January 1st of year y, counted from 0000-01-01.
  function automatic int unsigned year_start(int unsigned y);
    int unsigned p;
    if (y == 0) begin
      return 0;
    end
    p = y - 1;
    return 365 * y + p / 4 - p / 100 + p / 400 + 1;
  endfunction

  function automatic int unsigned date_ordinal(int unsigned y, int unsigned m,
                                               int unsigned d);
    int unsigned n;
    n = year_start(y);
    for (int unsigned k = 1; k < m && k <= 12; k++) begin
      n += month_length(y, k);
    end
    return n + d - 1;
  endfunction

  function automatic cal_date_t ordinal_to_date(int unsigned n);
    int unsigned y;
    int unsigned m;
    int unsigned len;
    cal_date_t   dt;
    y = 400 * (n / DAYS_PER_400Y);
    n = n % DAYS_PER_400Y;
    m = 1;
    len = is_leap(y) ? 366 : 365;
    while (n >= len) begin
      n -= len;
      y++;
      len = is_leap(y) ? 366 : 365;
    end
    while (m < 12 && n >= month_length(y, m)) begin
      n -= month_length(y, m);
      m++;
    end
    dt.year = 14'(y);
    dt.month = 4'(m);
    dt.day = 5'(n + 1);
    return dt;
  endfunction

  function automatic date_result_t predict_date_op(op_t op, int unsigned ay,
      int unsigned am, int unsigned ad, int unsigned by, int unsigned bm,
      int unsigned bd, int unsigned delta);
    date_result_t r;
    cal_date_t    dt;
    int unsigned  na;
    int unsigned  nb;
    int unsigned  n;
    int unsigned  last_day;
    r.year = '0;
    r.month = 4'd1;
    r.day = 5'd1;
    r.count = '0;
    r.order = ORD_EQUAL;
    r.valid = 1'b0;
    r.sat = 1'b0;
    if (ay > YEAR_MAX || am < 1 || am > 12 || ad < 1 || ad > month_length(ay, am)) begin
      return r;
    end
    r.valid = 1'b1;
    r.year = 14'(ay);
    r.month = 4'(am);
    r.day = 5'(ad);
    na = date_ordinal(ay, am, ad);
    last_day = year_start(32'(YEAR_MAX) + 1) - 1;
    // Date B is never rejected; each of its fields is pulled into range.
    if (by > YEAR_MAX) by = 32'(YEAR_MAX);
    if (bm < 1) bm = 1;
    if (bm > 12) bm = 12;
    if (bd < 1) bd = 1;
    if (bd > month_length(by, bm)) bd = month_length(by, bm);
    nb = date_ordinal(by, bm, bd);
    case (op)
      OP_ADD, OP_SUB: begin
        if (op == OP_ADD) begin
          n = na + delta;
          if (n > last_day) begin
            n = last_day;
            r.sat = 1'b1;
          end
        end else if (na < delta) begin
          n = 0;
          r.sat = 1'b1;
        end else begin
          n = na - delta;
        end
        dt = ordinal_to_date(n);
        r.year = dt.year;
        r.month = dt.month;
        r.day = dt.day;
      end
      OP_BETWEEN: begin
        n = (na > nb) ? na - nb : nb - na;
        if (n > COUNT_MAX) begin
          n = 32'(COUNT_MAX);
          r.sat = 1'b1;
        end
        r.count = 16'(n);
      end
      default: begin
        r.order = (na == nb) ? ORD_EQUAL : ((na < nb) ? ORD_BEFORE : ORD_AFTER);
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- sender
  task automatic send_word(input op_t op, input logic [13:0] ay, input logic [3:0] am,
                           input logic [4:0] ad, input logic [13:0] by,
                           input logic [3:0] bm, input logic [4:0] bd,
                           input logic [15:0] delta);
    date_result_t want;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_a_year <= ay;
    in_a_month <= am;
    in_a_day <= ad;
    in_b_year <= by;
    in_b_month <= bm;
    in_b_date_day <= bd;
    in_delta_days <= delta;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = predict_date_op(op, 32'(ay), 32'(am), 32'(ad), 32'(by), 32'(bm), 32'(bd),
                           32'(delta));
    expected_q.push_back(want);
    words_sent++;
    if (want.sat) sat_words++;
    if (!want.valid) invalid_words++;
  endtask

  // ---------------------------------------------------------------- checker
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
                                results_checked, name, got, want));
    end
  endtask

  always @(posedge clk) begin : result_side
    date_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result word arrived with nothing outstanding");
      end else begin
        want = expected_q.pop_front();
        check_field("res_year", int'(out_res_year), int'(want.year));
        check_field("res_month", int'(out_res_month), int'(want.month));
        check_field("res_day", int'(out_res_day), int'(want.day));
        check_field("days_count", int'(out_days_count), int'(want.count));
        check_field("order", int'(out_order), int'(want.order));
        check_field("input_valid", int'(out_input_valid), int'(want.valid));
        check_field("saturated", int'(out_saturated), int'(want.sat));
      end
      results_checked++;
    end
    out_stall <= (receiver_idle_pct != 0) && ($urandom_range(0, 99) < receiver_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d result words still outstanding.",
               cycle_count, expected_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  // Valid dates, with years pulled toward both ends of the range and days
  // often on the last of the month so that wraps are exercised.
  task automatic pick_valid_date(output logic [13:0] y, output logic [3:0] m,
                                 output logic [4:0] d);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) y = 14'($urandom_range(0, 3));
    else if (r == 1) y = 14'($urandom_range(9996, 9999));
    else y = 14'($urandom_range(0, 9999));
    m = 4'($urandom_range(1, 12));
    if ($urandom_range(0, 3) == 0) d = 5'(month_length(32'(y), 32'(m)));
    else d = 5'($urandom_range(1, month_length(32'(y), 32'(m))));
  endtask

  task automatic test_add_days();
    send_word(OP_ADD, 14'd2024, 4'd2, 5'd28, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_ADD, 14'd1900, 4'd2, 5'd28, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_ADD, 14'd2000, 4'd2, 5'd28, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_ADD, 14'd0, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1, 16'd65535);
    send_word(OP_ADD, 14'd9999, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_ADD, 14'd1999, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1, 16'd0);
  endtask

  task automatic test_sub_days();
    send_word(OP_SUB, 14'd0, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_SUB, 14'd2000, 4'd3, 5'd1, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_SUB, 14'd2100, 4'd3, 5'd1, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_SUB, 14'd9999, 4'd12, 5'd31, 14'd0, 4'd1, 5'd1, 16'd65535);
  endtask

  task automatic test_days_between();
    send_word(OP_BETWEEN, 14'd2000, 4'd1, 5'd1, 14'd2000, 4'd1, 5'd1, 16'd0);
    send_word(OP_BETWEEN, 14'd0, 4'd1, 5'd1, 14'd9999, 4'd12, 5'd31, 16'd0);
    send_word(OP_BETWEEN, 14'd2021, 4'd5, 5'd5, 14'd2020, 4'd5, 5'd5, 16'd0);
  endtask

  task automatic test_compare();
    send_word(OP_COMPARE, 14'd1600, 4'd2, 5'd29, 14'd1600, 4'd2, 5'd29, 16'd0);
    send_word(OP_COMPARE, 14'd1600, 4'd2, 5'd29, 14'd1600, 4'd3, 5'd1, 16'd0);
    send_word(OP_COMPARE, 14'd1600, 4'd3, 5'd1, 14'd1600, 4'd2, 5'd29, 16'd0);
  endtask

  task automatic test_invalid_a();
    send_word(OP_ADD, 14'd10000, 4'd1, 5'd1, 14'd0, 4'd1, 5'd1, 16'd5);
    send_word(OP_SUB, 14'd2000, 4'd0, 5'd1, 14'd0, 4'd1, 5'd1, 16'd5);
    send_word(OP_BETWEEN, 14'd2000, 4'd13, 5'd1, 14'd0, 4'd1, 5'd1, 16'd0);
    send_word(OP_COMPARE, 14'd2000, 4'd4, 5'd0, 14'd0, 4'd1, 5'd1, 16'd0);
    send_word(OP_ADD, 14'd2023, 4'd2, 5'd29, 14'd0, 4'd1, 5'd1, 16'd1);
    send_word(OP_SUB, 14'd16383, 4'd15, 5'd31, 14'd16383, 4'd15, 5'd31, 16'd65535);
  endtask

  task automatic test_b_clamping();
    send_word(OP_BETWEEN, 14'd9900, 4'd6, 5'd30, 14'd16383, 4'd15, 5'd31, 16'd0);
    send_word(OP_COMPARE, 14'd0, 4'd1, 5'd1, 14'd0, 4'd0, 5'd0, 16'd0);
    send_word(OP_BETWEEN, 14'd2023, 4'd3, 5'd1, 14'd2023, 4'd2, 5'd31, 16'd0);
  endtask

  task automatic test_random_mix(input int words, input int tx_pct, input int rx_pct);
    op_t         op;
    logic [13:0] ay;
    logic [3:0]  am;
    logic [4:0]  ad;
    logic [13:0] by;
    logic [3:0]  bm;
    logic [4:0]  bd;
    logic [15:0] delta;
    int          near_year;
    int unsigned r;
    sender_idle_pct = tx_pct;
    receiver_idle_pct = rx_pct;
    for (int i = 0; i < words; i++) begin
      op = op_t'($urandom_range(0, 3));
      if ($urandom_range(0, 9) < 2) begin
        ay = 14'($urandom_range(0, 16383));
        am = 4'($urandom_range(0, 15));
        ad = 5'($urandom_range(0, 31));
      end else begin
        pick_valid_date(ay, am, ad);
      end
      r = $urandom_range(0, 9);
      if (r < 5) begin
        // Keep B within reach of A so the count rarely clips.
        pick_valid_date(by, bm, bd);
        near_year = int'(ay) + int'($urandom_range(0, 300)) - 150;
        if (near_year < 0) near_year = 0;
        if (near_year > 9999) near_year = 9999;
        by = 14'(near_year);
        if (bd > month_length(32'(by), 32'(bm))) bd = 5'(month_length(32'(by), 32'(bm)));
      end else if (r < 8) begin
        pick_valid_date(by, bm, bd);
      end else begin
        by = 14'($urandom_range(0, 16383));
        bm = 4'($urandom_range(0, 15));
        bd = 5'($urandom_range(0, 31));
      end
      // Large deltas take many month steps, so only a few use the full range.
      if ($urandom_range(0, 15) == 0) delta = 16'($urandom_range(0, 65535));
      else delta = 16'($urandom_range(0, 1200));
      send_word(op, ay, am, ad, by, bm, bd, delta);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    sender_idle_pct = 34;
    receiver_idle_pct = 50;
    test_add_days();
    test_sub_days();
    test_days_between();
    test_compare();
    test_invalid_a();
    test_b_clamping();
    test_random_mix(82, 34, 50);
    test_random_mix(82, 50, 34);
    test_random_mix(82, 0, 0);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Checked %0d of %0d words over all four opcodes, three idling mixes.",
             results_checked, words_sent);
    $display("Of these, %0d clipped a date or count and %0d carried an invalid date A.",
             sat_words, invalid_words);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
